// ===== src/bqf_pkg.sv =====
// shared constants for the biquad filter with gain
package bqf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int GAIN_WIDTH       = 16;
  localparam int GAIN_FRAC        = 15;
  localparam int CFG_IDX_W        = 3;
  localparam int OP_W             = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd6;

  // multiply operations, in processing order
  localparam logic [OP_W-1:0] OP_GAIN_IN  = 3'd0;
  localparam logic [OP_W-1:0] OP_B0       = 3'd1;
  localparam logic [OP_W-1:0] OP_B1       = 3'd2;
  localparam logic [OP_W-1:0] OP_B2       = 3'd3;
  localparam logic [OP_W-1:0] OP_A1       = 3'd4;
  localparam logic [OP_W-1:0] OP_A2       = 3'd5;
  localparam logic [OP_W-1:0] OP_GAIN_OUT = 3'd6;

endpackage

// ===== src/bqf_smul.sv =====
// bit-serial signed multiplier, multiplier operand shifted lsb first
module bqf_smul #(
  parameter int MC = 32,
  parameter int ML = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic signed [MC-1:0]    mcand,
  input  logic signed [ML-1:0]    mplier,
  output logic                    done,
  output logic signed [MC+ML:0]   prod
);

  localparam int CW = (ML > 1) ? $clog2(ML) : 1;
  localparam logic [CW-1:0] LAST = CW'(ML - 1);

  logic signed [MC-1:0] cand_r;
  logic signed [MC:0]   part_r;
  logic [ML-1:0]        low_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [MC+1:0] part_ext;
  logic signed [MC+1:0] cand_ext;
  logic signed [MC+1:0] sum;
  logic                 last;

  assign last     = (cnt_r == LAST);
  assign part_ext = (MC+2)'(part_r);
  assign cand_ext = low_r[0] ? (MC+2)'(cand_r) : '0;

  // sign bit of the multiplier carries negative weight
  always_comb begin
    if (last) begin
      sum = part_ext - cand_ext;
    end else begin
      sum = part_ext + cand_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & last;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cand_r <= mcand;
      part_r <= '0;
      low_r  <= mplier;
    end else if (busy_r) begin
      part_r <= sum[MC+1:1];
      low_r  <= {sum[0], low_r[ML-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {part_r, low_r};

endmodule

// ===== src/biquad_iir_filter_with_gain.sv =====
// biquad direct form i filter with input and output gain, bit-serial multiply
// per word: load, multiply and accumulate for each operation, round after a2, then output
// a word is taken only once the last is output: seven passes share one serial multiplier
// each multiply retires one multiplier bit per cycle; ML = max(SAMPLE_WIDTH, 17) bits
// reset: synchronous active low; coefficients and history clear, gains return to unity
module biquad_iir_filter_with_gain #(
  parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COEF_WIDTH-1:0]          cfg_wdata
);

  import bqf_pkg::*;

  localparam int S         = SAMPLE_WIDTH;
  localparam int C         = COEF_WIDTH;
  localparam int COEF_FRAC = C - 4;
  localparam int MC        = (S > C) ? S : C;
  localparam int ML        = (S > GAIN_WIDTH + 1) ? S : GAIN_WIDTH + 1;
  localparam int PW        = MC + ML + 1;
  localparam int AW        = MC + ML + 3;

  localparam logic signed [AW-1:0] SAT_HI = {{(AW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-S+1){1'b1}}, {(S-1){1'b0}}};
  localparam logic signed [AW-1:0] G_HALF =
    {{(AW-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
  localparam logic signed [AW-1:0] C_HALF =
    {{(AW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = {1'b1, {(GAIN_WIDTH-1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_RND  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  function automatic logic signed [S-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [S-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[S-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[S-1:0];
    end else begin
      r = v[S-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [OP_W-1:0] op_r;

  logic signed [C-1:0]          coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic [GAIN_WIDTH-1:0]        in_gain_r, out_gain_r;
  logic signed [S-1:0]          sample_r, x_r, res_r;
  logic signed [S-1:0]          pi1_r, pi2_r, po1_r, po2_r;
  logic signed [AW-1:0]         acc_r;
  logic                         out_valid_r;
  logic signed [S-1:0]          out_sample_r;

  logic                         mul_load;
  logic                         mul_done;
  logic signed [MC-1:0]         mul_cand;
  logic signed [ML-1:0]         mul_plier;
  logic signed [PW-1:0]         mul_prod;
  logic signed [AW-1:0]         prod_ext;
  logic signed [AW-1:0]         gain_sum, gain_shr, filt_sum, filt_shr;
  logic signed [S-1:0]          gain_rnd, filt_rnd;
  logic                         sub_term;

  bqf_smul #(.MC(MC), .ML(ML)) u_smul (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (mul_load),
    .mcand  (mul_cand),
    .mplier (mul_plier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  assign mul_load = (state_r == S_LOAD);

  always_comb begin
    case (op_r)
      OP_GAIN_IN: begin
        mul_cand  = MC'(sample_r);
        mul_plier = ML'(in_gain_r);
      end
      OP_B0: begin
        mul_cand  = MC'(coef_b0_r);
        mul_plier = ML'(x_r);
      end
      OP_B1: begin
        mul_cand  = MC'(coef_b1_r);
        mul_plier = ML'(pi1_r);
      end
      OP_B2: begin
        mul_cand  = MC'(coef_b2_r);
        mul_plier = ML'(pi2_r);
      end
      OP_A1: begin
        mul_cand  = MC'(coef_a1_r);
        mul_plier = ML'(po1_r);
      end
      OP_A2: begin
        mul_cand  = MC'(coef_a2_r);
        mul_plier = ML'(po2_r);
      end
      default: begin
        mul_cand  = MC'(po1_r);
        mul_plier = ML'(out_gain_r);
      end
    endcase
  end

  // round half up then clamp
  assign prod_ext = AW'(mul_prod);
  assign gain_sum = prod_ext + G_HALF;
  assign gain_shr = gain_sum >>> GAIN_FRAC;
  assign gain_rnd = sat(gain_shr);
  assign filt_sum = acc_r + C_HALF;
  assign filt_shr = filt_sum >>> COEF_FRAC;
  assign filt_rnd = sat(filt_shr);

  assign sub_term = (op_r == OP_A1) || (op_r == OP_A2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (op_r == OP_A2) begin
          state_nxt = S_RND;
        end else if (op_r == OP_GAIN_OUT) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_RND: state_nxt = S_LOAD;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_GAIN_IN;
      out_valid_r <= 1'b0;
      coef_b0_r   <= '0;
      coef_b1_r   <= '0;
      coef_b2_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
      in_gain_r   <= GAIN_UNITY;
      out_gain_r  <= GAIN_UNITY;
      pi1_r       <= '0;
      pi2_r       <= '0;
      po1_r       <= '0;
      po2_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_B0:          coef_b0_r  <= cfg_wdata[C-1:0];
          REG_B1:          coef_b1_r  <= cfg_wdata[C-1:0];
          REG_B2:          coef_b2_r  <= cfg_wdata[C-1:0];
          REG_A1:          coef_a1_r  <= cfg_wdata[C-1:0];
          REG_A2:          coef_a2_r  <= cfg_wdata[C-1:0];
          REG_INPUT_GAIN:  in_gain_r  <= cfg_wdata[GAIN_WIDTH-1:0];
          REG_OUTPUT_GAIN: out_gain_r <= cfg_wdata[GAIN_WIDTH-1:0];
          default: ;
        endcase
      end
      if (state_r == S_IDLE && in_valid) begin
        op_r <= OP_GAIN_IN;
      end
      if (state_r == S_ACC || state_r == S_RND) begin
        if (op_r != OP_A2 || state_r == S_RND) begin
          op_r <= op_r + 1'b1;
        end
      end
      // history shifts once the filter output is known
      if (state_r == S_RND) begin
        pi2_r <= pi1_r;
        pi1_r <= x_r;
        po2_r <= po1_r;
        po1_r <= filt_rnd;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      sample_r <= in_sample_in;
      acc_r    <= '0;
    end
    if (state_r == S_ACC) begin
      if (op_r == OP_GAIN_IN) begin
        x_r <= gain_rnd;
      end else if (op_r == OP_GAIN_OUT) begin
        res_r <= gain_rnd;
      end else if (sub_term) begin
        acc_r <= acc_r - prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_sample_r <= res_r;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside multiply state");

  a_rnd_after_a2: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RND |-> $past(state_r == S_ACC && op_r == OP_A2))
    else $error("rounding step not preceded by last feedback term");

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output word raised outside output state");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> op_r <= OP_GAIN_OUT)
    else $error("operation index out of range");

endmodule

// ===== test/biquad_iir_filter_with_gain_tb.sv =====
// testbench for the biquad filter with gain: table-driven and random words checked against table values or a predictor
module biquad_iir_filter_with_gain_tb;
  import bqf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CW = COEF_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 160;
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 200;
  localparam longint SMP_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;

  typedef logic signed [SW-1:0] smp_t;

  localparam smp_t SMP_MAXV = {1'b0, {(SW-1){1'b1}}};
  localparam smp_t SMP_MINV = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_ONE = {{3{1'b0}}, 1'b1, {(CW-4){1'b0}}};
  localparam logic [CW-1:0] GAIN_ONE = 1 << GAIN_FRAC;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CW-1:0]        data;
    smp_t                 smp;
    logic                 typed;
    smp_t                 want;
  } tab_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  smp_t                 in_sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  smp_t                 out_sample_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CW-1:0]        cfg_wdata = '0;

  // filter state and settings as the block should hold them
  longint c_b0 = 0, c_b1 = 0, c_b2 = 0, c_a1 = 0, c_a2 = 0;
  longint g_in = 32768, g_out = 32768;
  longint x_d1 = 0, x_d2 = 0, y_d1 = 0, y_d2 = 0;

  smp_t     out_sample_q[$];
  tab_row_t dir_tab[$];
  int       snd_idle = 0;
  int       rcv_stall = 0;
  int       err_cnt = 0;
  int       hold_left = 0;
  logic     hold_tog = 1'b0;
  logic     hold_seen = 1'b0;

  biquad_iir_filter_with_gain uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint round_q(input longint a, input int s);
    return (a + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_smp(input longint v);
    if (v > SMP_HI) return SMP_HI;
    if (v < SMP_LO) return SMP_LO;
    return v;
  endfunction

  function automatic smp_t filter_word(input smp_t s);
    longint x, acc, y, r;
    x = clamp_smp(round_q(longint'(s) * g_in, GAIN_FRAC));
    acc = c_b0 * x + c_b1 * x_d1 + c_b2 * x_d2 - c_a1 * y_d1 - c_a2 * y_d2;
    y = clamp_smp(round_q(acc, CW - 4));
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = y;
    r = clamp_smp(round_q(y * g_out, GAIN_FRAC));
    return r[SW-1:0];
  endfunction

  function automatic smp_t pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      1: begin
        case (r[1:0])
          2'd0: pick_sample = SMP_MAXV;
          2'd1: pick_sample = SMP_MINV;
          2'd2: pick_sample = '0;
          default: pick_sample = '1;
        endcase
      end
      2: pick_sample = $signed(r[10:0]);
      default: pick_sample = r[SW-1:0];
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_coef(input int kind);
    logic [CW-1:0] r;
    r = $urandom;
    case (kind)
      0: pick_coef = r;
      1: pick_coef = {{4{r[CW-4]}}, r[CW-5:0]};
      default: begin
        case (r[1:0])
          2'd0: pick_coef = COEF_MAX;
          2'd1: pick_coef = COEF_MIN;
          2'd2: pick_coef = '0;
          default: pick_coef = COEF_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_gain();
    logic [CW-1:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: pick_gain = r;
      1: pick_gain = GAIN_ONE + CW'($signed(r[11:0]));
      2: pick_gain = r[0] ? 32'h0000_ffff : 32'h0000_0000;
      default: pick_gain = {r[CW-1:GAIN_WIDTH], 16'h8000};
    endcase
  endfunction

  task automatic tab_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    dir_tab.push_back({1'b1, idx, data, {SW{1'b0}}, 1'b0, {SW{1'b0}}});
  endtask

  task automatic tab_word(input smp_t s, input logic typed, input smp_t want);
    dir_tab.push_back({1'b0, {CFG_IDX_W{1'b0}}, {CW{1'b0}}, s, typed, want});
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_B0: c_b0 = longint'($signed(data));
      REG_B1: c_b1 = longint'($signed(data));
      REG_B2: c_b2 = longint'($signed(data));
      REG_A1: c_a1 = longint'($signed(data));
      REG_A2: c_a2 = longint'($signed(data));
      REG_INPUT_GAIN: g_in = longint'(data[GAIN_WIDTH-1:0]);
      REG_OUTPUT_GAIN: g_out = longint'(data[GAIN_WIDTH-1:0]);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (out_sample_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input smp_t s, input logic typed, input smp_t want);
    smp_t pred;
    if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(400, 1)) @(posedge clk);
      else repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    pred = filter_word(s);
    out_sample_q.push_back(typed ? want : pred);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin : out_check
    smp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_sample_q.size() == 0) begin
        $display("%0t: sample_out expected none, actual %0d", $time, out_sample_out);
        err_cnt++;
      end else begin
        want = out_sample_q.pop_front();
        if (out_sample_out !== want) begin
          $display("%0t: sample_out expected %0d, actual %0d", $time, want, out_sample_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int kind;
    // coefficients zero after reset
    tab_word(SMP_MAXV, 1'b1, '0);
    tab_word(SMP_MINV, 1'b1, '0);
    tab_cfg(REG_B0, COEF_ONE);
    tab_word(SMP_MAXV, 1'b1, SMP_MAXV);
    tab_word(SMP_MINV, 1'b1, SMP_MINV);
    tab_word(24'sd1, 1'b1, 24'sd1);
    // saturation
    tab_cfg(REG_B0, COEF_MAX);
    tab_word(SMP_MAXV, 1'b1, SMP_MAXV);
    tab_word(SMP_MINV, 1'b1, SMP_MINV);
    tab_cfg(REG_B0, COEF_MIN);
    tab_word(SMP_MAXV, 1'b1, SMP_MINV);
    tab_word(SMP_MINV, 1'b1, SMP_MAXV);
    tab_word('0, 1'b1, '0);
    // zero gain with excess bits set, then gains at their ends
    tab_cfg(REG_INPUT_GAIN, 32'hffff_0000);
    tab_word(SMP_MAXV, 1'b1, '0);
    tab_cfg(REG_INPUT_GAIN, 32'h0000_ffff);
    tab_word(SMP_MAXV, 1'b1, SMP_MINV);
    tab_cfg(REG_OUTPUT_GAIN, '0);
    tab_word(24'sh123456, 1'b1, '0);
    tab_cfg(REG_OUTPUT_GAIN, 32'h0000_ffff);
    tab_word(SMP_MINV, 1'b0, '0);
    // unknown index is ignored
    tab_cfg(REG_UNUSED, 32'h1234_5678);
    tab_cfg(REG_B0, COEF_ONE);
    tab_cfg(REG_INPUT_GAIN, GAIN_ONE);
    tab_cfg(REG_OUTPUT_GAIN, GAIN_ONE);
    tab_cfg(REG_B1, 32'h0800_0000);
    tab_cfg(REG_B2, 32'hf000_0000);
    tab_cfg(REG_A1, COEF_MAX);
    tab_cfg(REG_A2, COEF_MIN);
    tab_word(SMP_MAXV, 1'b0, '0);
    tab_word(SMP_MINV, 1'b0, '0);
    tab_word(24'sd1, 1'b0, '0);
    tab_word('1, 1'b0, '0);
    tab_word(24'sh400000, 1'b0, '0);
    tab_word(24'shc00000, 1'b0, '0);
    tab_cfg(REG_A1, 32'he000_0000);
    tab_cfg(REG_A2, 32'h0400_0000);
    tab_word(SMP_MAXV, 1'b0, '0);
    tab_word('0, 1'b0, '0);
    tab_word(SMP_MINV, 1'b0, '0);
    tab_word('0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_word(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      kind = (ph == PHASES - 1) ? 2 : ph % 3;
      cfg_write(REG_B0, pick_coef(kind));
      cfg_write(REG_B1, pick_coef(kind));
      cfg_write(REG_B2, pick_coef(kind));
      cfg_write(REG_A1, pick_coef(kind));
      cfg_write(REG_A2, pick_coef(kind));
      cfg_write(REG_INPUT_GAIN, pick_gain());
      cfg_write(REG_OUTPUT_GAIN, pick_gain());
      cfg_write(REG_UNUSED, $urandom);
      case (ph % 4)
        0: begin snd_idle = 0;  rcv_stall <= 0;  end
        1: begin snd_idle = 65; rcv_stall <= 0;  end
        2: begin snd_idle = 0;  rcv_stall <= 65; end
        default: begin snd_idle = 9; rcv_stall <= 9; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long receiver hold-off while words keep coming
        if (ph == 2 && n == 20) hold_tog <= ~hold_tog;
        // sender waits for the pipe to empty
        if (ph == 5 && n == 80) settle();
        send_word(pick_sample(), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bqf_pkg.sv
src/bqf_smul.sv
src/biquad_iir_filter_with_gain.sv
test/biquad_iir_filter_with_gain_tb.sv
